>>> rtl/joystick_deadzone_to_mouse_defines.svh
// Assertion macros shared by the joystick-to-mouse RTL.
// Users must provide clk and rst_n in scope; no other dependencies.
`ifndef JOYSTICK_DEADZONE_TO_MOUSE_DEFINES_SVH
`define JOYSTICK_DEADZONE_TO_MOUSE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define JDM_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define JDM_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

>>> rtl/jdm_pkg.sv
// Shared constants for the joystick dead-zone to mouse converter.
// No dependencies; imported by joystick_deadzone_to_mouse.
package jdm_pkg;

    localparam int FS_W     = 7;
    localparam int PERIOD_W = 8;
    localparam int MOVE_W   = 8;
    localparam int QUO_W    = 7;
    localparam int BIT_W    = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam int OUT_W    = 24;

    localparam logic [CFG_ADDR_W-1:0] CFG_FULL_SCALE    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPORT_PERIOD = 1'b1;

    localparam logic [FS_W-1:0]     FULL_SCALE_RST    = 7'd20;
    localparam logic [PERIOD_W-1:0] REPORT_PERIOD_RST = 8'd100;

endpackage

>>> rtl/joystick_deadzone_to_mouse.sv
// Joystick to relative-mouse converter with self-calibrating dead zone; uses jdm_pkg.
// Timing: a non-report sample is absorbed in its accept cycle; a report sample keeps the
// block busy (per axis: set-up, up to 7 divide steps on the shared subtractor and store;
// then the report state, which waits while an earlier request is still held).
// Throughput: one non-report sample per cycle while idle; no sample is taken while busy.
// Reset (rst_n, asynchronous) restores register defaults and clears calibration.
module joystick_deadzone_to_mouse #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [jdm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [jdm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: x_sample, y_sample, button_level, zero padding.
    input  logic [((2*SAMPLE_BITS+8)/8)*8-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: move_x, move_y, left_pressed, zero padding.
    output logic [jdm_pkg::OUT_W-1:0]            m_axis_tdata
);
    import jdm_pkg::*;
    `include "joystick_deadzone_to_mouse_defines.svh"

    localparam int NUM_W = SAMPLE_BITS + FS_W;
    localparam logic [SAMPLE_BITS-1:0] FULL_CODE = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_STORE,
        ST_REPORT
    } state_t;

    state_t                   state_reg, state_next;
    logic                     axis_reg, axis_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;
    logic [SAMPLE_BITS-1:0]   samp_reg [2];
    logic [SAMPLE_BITS-1:0]   samp_next [2];
    logic                     btn_reg, btn_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [SAMPLE_BITS-1:0]   den_reg, den_next;
    logic                     neg_reg, neg_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic [MOVE_W-1:0]        move_reg [2];
    logic [MOVE_W-1:0]        move_next [2];
    logic [PERIOD_W-1:0]      count_reg, count_next;
    logic                     calibrated_reg, calibrated_next;
    logic [SAMPLE_BITS-1:0]   low_reg [2];
    logic [SAMPLE_BITS-1:0]   low_next [2];
    logic [SAMPLE_BITS-1:0]   high_reg [2];
    logic [SAMPLE_BITS-1:0]   high_next [2];
    logic [MOVE_W-1:0]        last_reg [2];
    logic [MOVE_W-1:0]        last_next [2];
    logic                     last_btn_reg, last_btn_next;
    logic [FS_W-1:0]          full_scale_reg, full_scale_next;
    logic [PERIOD_W-1:0]      period_reg, period_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]         out_data_reg, out_data_next;

    logic [SAMPLE_BITS-1:0]   in_x;
    logic [SAMPLE_BITS-1:0]   in_y;
    logic                     in_btn;
    logic                     accept;
    logic                     due;
    logic [SAMPLE_BITS-1:0]   cur_v;
    logic [SAMPLE_BITS-1:0]   cur_lo;
    logic [SAMPLE_BITS-1:0]   cur_hi;
    logic                     below;
    logic                     in_zone;
    logic [SAMPLE_BITS-1:0]   delta;
    logic [SAMPLE_BITS-1:0]   span;
    logic [NUM_W-1:0]         den_shift;
    logic [NUM_W:0]           trial;
    logic                     emit;

    assign in_x   = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_y   = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign in_btn = s_axis_tdata[2*SAMPLE_BITS];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign due           = (count_reg >= period_reg);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign cur_v   = samp_reg[axis_reg];
    assign cur_lo  = low_reg[axis_reg];
    assign cur_hi  = high_reg[axis_reg];
    assign below   = (cur_v < cur_lo);
    assign in_zone = !below && (cur_v <= cur_hi);
    assign delta   = below ? (cur_lo - cur_v) : (cur_v - cur_hi);
    assign span    = below ? cur_lo : (FULL_CODE - cur_hi);

    // The single shared subtractor serving every restoring divide step.
    assign den_shift = NUM_W'(den_reg) << bit_reg;
    assign trial     = {1'b0, num_reg} - {1'b0, den_shift};

    assign emit = (move_reg[0] != '0) || (move_reg[1] != '0) ||
                  (last_reg[0] != '0) || (last_reg[1] != '0) ||
                  (btn_reg != last_btn_reg) || btn_reg;

    always_comb
    begin
        state_next      = state_reg;
        axis_next       = axis_reg;
        bit_next        = bit_reg;
        samp_next       = samp_reg;
        btn_next        = btn_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        neg_next        = neg_reg;
        quo_next        = quo_reg;
        move_next       = move_reg;
        count_next      = count_reg;
        calibrated_next = calibrated_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        last_next       = last_reg;
        last_btn_next   = last_btn_reg;
        full_scale_next = full_scale_reg;
        period_next     = period_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;

        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_FULL_SCALE:    full_scale_next = cfg_wdata[FS_W-1:0];
                CFG_REPORT_PERIOD: period_next     = cfg_wdata[PERIOD_W-1:0];
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    samp_next[0] = in_x;
                    samp_next[1] = in_y;
                    btn_next     = in_btn;
                    if (!due)
                    begin
                        count_next = count_reg + 1'b1;
                        if (!calibrated_reg)
                        begin
                            if (in_x > high_reg[0]) high_next[0] = in_x;
                            if (in_x < low_reg[0])  low_next[0]  = in_x;
                            if (in_y > high_reg[1]) high_next[1] = in_y;
                            if (in_y < low_reg[1])  low_next[1]  = in_y;
                        end
                    end
                    else
                    begin
                        count_next      = '0;
                        calibrated_next = 1'b1;
                        axis_next       = 1'b0;
                        state_next      = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                num_next = NUM_W'(full_scale_reg) * NUM_W'(delta);
                den_next = span;
                neg_next = below;
                quo_next = '0;
                bit_next = BIT_W'(QUO_W - 1);
                if (in_zone || (span == '0))
                    state_next = ST_STORE;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!trial[NUM_W])
                begin
                    num_next          = trial[NUM_W-1:0];
                    quo_next[bit_reg] = 1'b1;
                end
                if (bit_reg == '0)
                    state_next = ST_STORE;
                else
                    bit_next = bit_reg - 1'b1;
            end
            ST_STORE:
            begin
                move_next[axis_reg] = neg_reg ? (MOVE_W'(0) - MOVE_W'(quo_reg))
                                              : MOVE_W'(quo_reg);
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = ST_SETUP;
                end
                else
                    state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (!emit)
                    state_next = ST_IDLE;
                else if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {(OUT_W - 2*MOVE_W - 1)'(0), btn_reg,
                                      move_reg[1], move_reg[0]};
                    last_next      = move_reg;
                    last_btn_next  = btn_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            axis_reg       <= 1'b0;
            bit_reg        <= '0;
            samp_reg[0]    <= '0;
            samp_reg[1]    <= '0;
            btn_reg        <= 1'b0;
            num_reg        <= '0;
            den_reg        <= '0;
            neg_reg        <= 1'b0;
            quo_reg        <= '0;
            move_reg[0]    <= '0;
            move_reg[1]    <= '0;
            count_reg      <= '0;
            calibrated_reg <= 1'b0;
            low_reg[0]     <= '1;
            low_reg[1]     <= '1;
            high_reg[0]    <= '0;
            high_reg[1]    <= '0;
            last_reg[0]    <= '0;
            last_reg[1]    <= '0;
            last_btn_reg   <= 1'b0;
            full_scale_reg <= FULL_SCALE_RST;
            period_reg     <= REPORT_PERIOD_RST;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            axis_reg       <= axis_next;
            bit_reg        <= bit_next;
            samp_reg       <= samp_next;
            btn_reg        <= btn_next;
            num_reg        <= num_next;
            den_reg        <= den_next;
            neg_reg        <= neg_next;
            quo_reg        <= quo_next;
            move_reg       <= move_next;
            count_reg      <= count_next;
            calibrated_reg <= calibrated_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            last_reg       <= last_next;
            last_btn_reg   <= last_btn_next;
            full_scale_reg <= full_scale_next;
            period_reg     <= period_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

    `JDM_ASSERT_NEXT(a_report_resets_count, accept && due,
        calibrated_reg && (count_reg == '0) && (state_reg == ST_SETUP),
        "report sample did not restart the counter")
    `JDM_ASSERT_NOW(a_quotient_bounded, state_reg == ST_STORE,
        quo_reg <= full_scale_reg, "displacement exceeds full scale")
    `JDM_ASSERT_NEXT(a_calibration_sticky, calibrated_reg, calibrated_reg,
        "calibration flag cleared outside reset")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for joystick_deadzone_to_mouse: directed rows, then random samples.
// Depends on jdm_pkg and the block under rtl; it predicts reports with its own model or typed rows.
module testbench;
    import jdm_pkg::*;

    localparam int SAMPLE_BITS    = 12;
    localparam int IN_W           = ((2 * SAMPLE_BITS + 8) / 8) * 8;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int QUIET_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 7;
    localparam int NUM_ROWS       = 23;

    localparam int PHASE_SCALE [NUM_PHASES]  = '{127, 1, 64, 20, 127, 5, 100};
    localparam int PHASE_PERIOD [NUM_PHASES] = '{1, 255, 2, 100, 0, 3, 7};
    localparam int PHASE_ITEMS [NUM_PHASES]  = '{300, 260, 300, 210, 200, 300, 360};

    typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;
    typedef enum logic [1:0] {RES_MODEL, RES_TYPED, RES_NONE} result_t;

    typedef struct packed {
        logic signed [MOVE_W-1:0] dx;
        logic signed [MOVE_W-1:0] dy;
        logic                     btn;
    } report_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_ADDR_W-1:0]    addr;
        logic [CFG_DATA_W-1:0]    value;
        logic [SAMPLE_BITS-1:0]   x;
        logic [SAMPLE_BITS-1:0]   y;
        logic                     btn;
        result_t                  chk;
        logic signed [MOVE_W-1:0] dx;
        logic signed [MOVE_W-1:0] dy;
        logic                     eb;
    } dir_row_t;

    // The first report locks the dead zone to [2000, 2100] on both axes.
    localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{ROW_CFG, CFG_FULL_SCALE, 8'd127, 12'd0, 12'd0, 1'b0, RES_NONE, 8'sd0, 8'sd0, 1'b0},
        '{ROW_CFG, CFG_REPORT_PERIOD, 8'd3, 12'd0, 12'd0, 1'b0, RES_NONE, 8'sd0, 8'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd2000, 12'd2100, 1'b0, RES_MODEL,
          8'sd0, 8'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd2100, 12'd2000, 1'b1, RES_MODEL,
          8'sd0, 8'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd2050, 12'd2050, 1'b0, RES_MODEL,
          8'sd0, 8'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd0, 12'd4095, 1'b1, RES_TYPED,
          -8'sd127, 8'sd127, 1'b1},
        '{ROW_CFG, CFG_REPORT_PERIOD, 8'd0, 12'd0, 12'd0, 1'b0, RES_NONE, 8'sd0, 8'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd2050, 12'd2050, 1'b0, RES_TYPED,
          8'sd0, 8'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd2050, 12'd2050, 1'b0, RES_NONE,
          8'sd0, 8'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd2000, 12'd2100, 1'b1, RES_TYPED,
          8'sd0, 8'sd0, 1'b1},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd2100, 12'd2000, 1'b1, RES_TYPED,
          8'sd0, 8'sd0, 1'b1},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd1999, 12'd2101, 1'b0, RES_MODEL,
          8'sd0, 8'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd4095, 12'd0, 1'b0, RES_TYPED,
          8'sd127, -8'sd127, 1'b0},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd4095, 12'd4095, 1'b1, RES_TYPED,
          8'sd127, 8'sd127, 1'b1},
        '{ROW_CFG, CFG_FULL_SCALE, 8'd0, 12'd0, 12'd0, 1'b0, RES_NONE, 8'sd0, 8'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd0, 12'd0, 1'b1, RES_TYPED,
          8'sd0, 8'sd0, 1'b1},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd0, 12'd4095, 1'b0, RES_TYPED,
          8'sd0, 8'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd4095, 12'd0, 1'b0, RES_NONE,
          8'sd0, 8'sd0, 1'b0},
        '{ROW_CFG, CFG_FULL_SCALE, 8'd1, 12'd0, 12'd0, 1'b0, RES_NONE, 8'sd0, 8'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd0, 12'd0, 1'b0, RES_TYPED,
          -8'sd1, -8'sd1, 1'b0},
        '{ROW_CFG, CFG_REPORT_PERIOD, 8'd255, 12'd0, 12'd0, 1'b0, RES_NONE,
          8'sd0, 8'sd0, 1'b0},
        '{ROW_CFG, CFG_FULL_SCALE, 8'd64, 12'd0, 12'd0, 1'b0, RES_NONE, 8'sd0, 8'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_FULL_SCALE, 8'd0, 12'd3000, 12'd1000, 1'b1, RES_MODEL,
          8'sd0, 8'sd0, 1'b0}
    };

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // Fields from bit 0: x_sample, y_sample, button_level, zero padding.
    logic [IN_W-1:0]         s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // Fields from bit 0: move_x, move_y, left_pressed, zero padding.
    logic [OUT_W-1:0]        m_axis_tdata;

    logic [FS_W-1:0]         scale_cfg;
    logic [PERIOD_W-1:0]     period_cfg;
    logic [PERIOD_W-1:0]     sample_cnt;
    logic                    cal_done;
    logic [SAMPLE_BITS-1:0]  zone_lo [2];
    logic [SAMPLE_BITS-1:0]  zone_hi [2];
    logic signed [MOVE_W-1:0] prev_move [2];
    logic                    prev_btn;

    report_t pending_reports [$];
    int      err_count   = 0;
    int      idle_cycles = 0;
    int      tx_burst    = 0;
    int      rx_burst    = 0;

    joystick_deadzone_to_mouse #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic signed [MOVE_W-1:0] axis_move(
        input logic [SAMPLE_BITS-1:0] v,
        input logic [SAMPLE_BITS-1:0] lo,
        input logic [SAMPLE_BITS-1:0] hi,
        input logic [FS_W-1:0]        fs
    );
        int mag;
        if (v >= lo && v <= hi)
        begin
            return '0;
        end
        if (v < lo)
        begin
            mag = (lo == 0) ? 0 : (int'(fs) * (int'(lo) - int'(v))) / int'(lo);
            return MOVE_W'(-mag);
        end
        mag = (int'(hi) == SAMPLE_MAX) ? 0 :
              (int'(fs) * (int'(v) - int'(hi))) / (SAMPLE_MAX - int'(hi));
        return MOVE_W'(mag);
    endfunction

    task automatic mouse_model_step(
        input  logic [SAMPLE_BITS-1:0] x,
        input  logic [SAMPLE_BITS-1:0] y,
        input  logic                   b,
        output bit                     fired,
        output report_t                rep
    );
        logic [SAMPLE_BITS-1:0]   smp [2];
        logic signed [MOVE_W-1:0] mv [2];
        int a;
        smp[0] = x;
        smp[1] = y;
        fired = 1'b0;
        rep = '0;
        if (sample_cnt < period_cfg)
        begin
            sample_cnt = sample_cnt + 1'b1;
            if (!cal_done)
            begin
                for (a = 0; a < 2; a++)
                begin
                    if (smp[a] > zone_hi[a])
                        zone_hi[a] = smp[a];
                    if (smp[a] < zone_lo[a])
                        zone_lo[a] = smp[a];
                end
            end
            return;
        end
        sample_cnt = '0;
        cal_done = 1'b1;
        for (a = 0; a < 2; a++)
            mv[a] = axis_move(smp[a], zone_lo[a], zone_hi[a], scale_cfg);
        if (mv[0] != 0 || mv[1] != 0 || prev_move[0] != 0 || prev_move[1] != 0 ||
            b != prev_btn || b)
        begin
            prev_move[0] = mv[0];
            prev_move[1] = mv[1];
            prev_btn = b;
            fired = 1'b1;
            rep.dx = mv[0];
            rep.dy = mv[1];
            rep.btn = b;
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (addr == CFG_FULL_SCALE)
            scale_cfg = value[FS_W-1:0];
        else
            period_cfg = value;
    endtask

    task automatic wait_quiet();
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] x,
                               input logic [SAMPLE_BITS-1:0] y,
                               input logic                   b);
        int gap;
        if (tx_burst > 0)
        begin
            gap = 0;
            tx_burst--;
        end
        else
        begin
            if ($urandom_range(0, 49) == 0)
                tx_burst = $urandom_range(10, 40);
            gap = $urandom_range(0, 11);
        end
        repeat (gap) @(negedge clk);
        s_axis_tdata = '0;
        s_axis_tdata[SAMPLE_BITS-1:0] = x;
        s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] = y;
        s_axis_tdata[2*SAMPLE_BITS] = b;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_axis_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
        return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    endfunction

    // Checks every report request against the oldest prediction.
    initial
    begin
        report_t want;
        logic signed [MOVE_W-1:0] got_dx;
        logic signed [MOVE_W-1:0] got_dy;
        logic got_btn;
        int stall;
        m_axis_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (rx_burst > 0)
            begin
                stall = 0;
                rx_burst--;
            end
            else
            begin
                if ($urandom_range(0, 49) == 0)
                    rx_burst = $urandom_range(10, 40);
                stall = $urandom_range(0, 11);
            end
            m_axis_tready = 1'b0;
            repeat (stall) @(negedge clk);
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got_dx = m_axis_tdata[MOVE_W-1:0];
            got_dy = m_axis_tdata[2*MOVE_W-1:MOVE_W];
            got_btn = m_axis_tdata[2*MOVE_W];
            if (pending_reports.size() == 0)
            begin
                if (err_count < 10)
                    $display("Unexpected report: dx=%0d dy=%0d btn=%0d",
                             got_dx, got_dy, got_btn);
                err_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got_dx !== want.dx || got_dy !== want.dy || got_btn !== want.btn)
                begin
                    if (err_count < 10)
                    begin
                        $write("Report mismatch: expected dx=%0d dy=%0d btn=%0d, ",
                               want.dx, want.dy, want.btn);
                        $display("got dx=%0d dy=%0d btn=%0d", got_dx, got_dy, got_btn);
                    end
                    err_count++;
                end
            end
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        bit fired;
        report_t rep;
        dir_row_t row;
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;
        logic held_btn;
        logic at_rest;
        int p;
        int n;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        scale_cfg = FULL_SCALE_RST;
        period_cfg = REPORT_PERIOD_RST;
        sample_cnt = '0;
        cal_done = 1'b0;
        zone_lo[0] = '1;
        zone_lo[1] = '1;
        zone_hi[0] = '0;
        zone_hi[1] = '0;
        prev_move[0] = '0;
        prev_move[1] = '0;
        prev_btn = 1'b0;
        held_btn = 1'b0;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        for (p = 0; p < NUM_ROWS; p++)
        begin
            row = DIRECTED_ROWS[p];
            if (row.kind == ROW_CFG)
            begin
                wait_quiet();
                write_reg(row.addr, row.value);
            end
            else
            begin
                send_sample(row.x, row.y, row.btn);
                mouse_model_step(row.x, row.y, row.btn, fired, rep);
                case (row.chk)
                    RES_MODEL:
                    begin
                        if (fired)
                            pending_reports.push_back(rep);
                    end
                    RES_TYPED:
                    begin
                        rep.dx = row.dx;
                        rep.dy = row.dy;
                        rep.btn = row.eb;
                        pending_reports.push_back(rep);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_quiet();
            write_reg(CFG_FULL_SCALE, CFG_DATA_W'(PHASE_SCALE[p]));
            write_reg(CFG_REPORT_PERIOD, CFG_DATA_W'(PHASE_PERIOD[p]));
            for (n = 0; n < PHASE_ITEMS[p]; n++)
            begin
                // A sample inside the dead zone on both axes lets motion settle to zero.
                at_rest = ($urandom_range(0, 7) < 3);
                if (at_rest)
                begin
                    x = SAMPLE_BITS'($urandom_range(zone_lo[0], zone_hi[0]));
                    y = SAMPLE_BITS'($urandom_range(zone_lo[1], zone_hi[1]));
                end
                else
                begin
                    x = pick_axis_value();
                    y = pick_axis_value();
                end
                if ($urandom_range(0, 3) == 0)
                    held_btn = ~held_btn;
                send_sample(x, y, held_btn);
                mouse_model_step(x, y, held_btn, fired, rep);
                if (fired)
                    pending_reports.push_back(rep);
                if ($urandom_range(0, 149) == 0)
                begin
                    while (pending_reports.size() != 0)
                        @(negedge clk);
                end
            end
        end

        wait_quiet();
        if (err_count == 0 && pending_reports.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/jdm_pkg.sv
rtl/joystick_deadzone_to_mouse.sv
bench/testbench.sv
